// ----- rtl/core/nxs_pkg.sv -----
// ----------------------------------------------------------------------------
// nxs_pkg
// Shared types, constants and helpers for the nixie cathode scrub sequencer.
// ----------------------------------------------------------------------------
package nxs_pkg;

   localparam int TIME_W        = 40;
   localparam int BRIGHT_W      = 8;
   localparam int DIGIT_W       = 4;
   localparam int STEP_W        = 8;
   localparam int PERIOD_W      = 17;
   localparam int DURATION_W    = 22;
   localparam int PERIOD_MS_W   = 27;
   localparam int CSR_DATA_W    = 22;
   localparam int CSR_INDEX_W   = 1;
   localparam int DIGIT_PORTS   = 6;

   localparam int TUBE_COUNT       = 6;
   localparam int STEP_INTERVAL_MS = 120;
   localparam int MS_PER_SECOND    = 1000;

   localparam logic [PERIOD_W-1:0]   RESET_PERIOD_SECONDS = PERIOD_W'(600);
   localparam logic [DURATION_W-1:0] RESET_DURATION_MS    = DURATION_W'(12000);
   localparam logic [BRIGHT_W-1:0]   SCRUB_BRIGHTNESS     = BRIGHT_W'(255);

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_SECONDS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION_MILLIS = 1'b1;

   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_TRIGGER = 1'b1;

   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [BRIGHT_W-1:0] bright_type;
   typedef logic [DIGIT_W-1:0]  digit_type;

   typedef struct packed {
      logic       action;
      time_type   now_millis;
      bright_type current_brightness;
   } item_type;

   typedef struct packed {
      logic                             running;
      logic                             digits_update;
      logic [DIGIT_PORTS-1:0][DIGIT_W-1:0] digit;
      logic                             brightness_write;
      bright_type                       brightness_level;
      logic                             colon_off;
   } result_type;

   typedef struct packed {
      logic [PERIOD_MS_W-1:0] period_ms;
      logic [DURATION_W-1:0]  run_len_ms;
   } cfg_type;

   // x mod 10 for x below 1029: quotient by reciprocal 205/2048
   function automatic digit_type mod10(input logic [STEP_W:0] x);
      logic [STEP_W+8:0] prod;
      logic [STEP_W:0]   q;
      logic [STEP_W:0]   r;
      prod = (STEP_W+9)'(x) * (STEP_W+9)'(205);
      q    = (STEP_W+1)'(prod >> 11);
      r    = x - (STEP_W+1)'(q * (STEP_W+1)'(10));
      return DIGIT_W'(r);
   endfunction

endpackage

// ----- rtl/core/nxs_req_if.sv -----
// ----------------------------------------------------------------------------
// nxs_req_if
// Input item channel: trigger or timestamped tick with current brightness.
// ----------------------------------------------------------------------------
interface nxs_req_if;
   import nxs_pkg::*;

   logic       valid;
   logic       ready;
   logic       action;
   time_type   now_millis;
   bright_type current_brightness;

   modport source (output valid, action, now_millis, current_brightness, input ready);
   modport sink   (input valid, action, now_millis, current_brightness, output ready);

endinterface

// ----- rtl/core/nxs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// nxs_rsp_if
// Result item channel: display ownership, digit, brightness and colon commands.
// ----------------------------------------------------------------------------
interface nxs_rsp_if;
   import nxs_pkg::*;

   logic       valid;
   logic       ready;
   logic       running;
   logic       digits_update;
   digit_type  digit_zero;
   digit_type  digit_one;
   digit_type  digit_two;
   digit_type  digit_three;
   digit_type  digit_four;
   digit_type  digit_five;
   logic       brightness_write;
   bright_type brightness_level;
   logic       colon_off;

   modport source (output valid, running, digits_update, digit_zero, digit_one,
                   digit_two, digit_three, digit_four, digit_five,
                   brightness_write, brightness_level, colon_off, input ready);
   modport sink   (input valid, running, digits_update, digit_zero, digit_one,
                   digit_two, digit_three, digit_four, digit_five,
                   brightness_write, brightness_level, colon_off, output ready);

endinterface

// ----- rtl/core/nixie_cathode_scrub_sequencer.sv -----
// ----------------------------------------------------------------------------
// nixie_cathode_scrub_sequencer
// Top level: input register, scrub decision logic, result register.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled and returns exactly one result per
// item: it is captured in an input register, decided against the run state in
// one pass of compare-and-select logic, and lands in a result register once it
// is empty or being read. The input side keeps accepting while a result waits,
// if the input register is empty or can move forward. Configuration writes take
// effect on the next clock and should be made while no items are in flight.
module nixie_cathode_scrub_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   nxs_req_if.sink                         req_chan,
   nxs_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [nxs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nxs_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import nxs_pkg::*;

   cfg_type    cfg;
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   result_type step_result;
   logic       advance;
   logic       req_take;

   nxs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   nxs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
      end
      if (req_take) begin
         s1_item_in.action             = req_chan.action;
         s1_item_in.now_millis         = req_chan.now_millis;
         s1_item_in.current_brightness = req_chan.current_brightness;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.running          = rsp_data_ff.running;
   assign rsp_chan.digits_update    = rsp_data_ff.digits_update;
   assign rsp_chan.digit_zero       = rsp_data_ff.digit[0];
   assign rsp_chan.digit_one        = rsp_data_ff.digit[1];
   assign rsp_chan.digit_two        = rsp_data_ff.digit[2];
   assign rsp_chan.digit_three      = rsp_data_ff.digit[3];
   assign rsp_chan.digit_four       = rsp_data_ff.digit[4];
   assign rsp_chan.digit_five       = rsp_data_ff.digit[5];
   assign rsp_chan.brightness_write = rsp_data_ff.brightness_write;
   assign rsp_chan.brightness_level = rsp_data_ff.brightness_level;
   assign rsp_chan.colon_off        = rsp_data_ff.colon_off;

   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty result register");

   a_colon_with_brightness: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.colon_off |-> rsp_data_ff.brightness_write)
      else $error("colon off without brightness write");

   a_digits_only_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.digits_update |-> rsp_data_ff.running)
      else $error("digit update while not running");

   a_digits_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.digits_update |-> rsp_data_ff.digit == '0)
      else $error("digits nonzero without update");

endmodule

// ----- rtl/core/nxs_csr.sv -----
// ----------------------------------------------------------------------------
// nxs_csr
// Configuration registers; the period is held pre-scaled to milliseconds.
// ----------------------------------------------------------------------------
module nxs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [nxs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nxs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output nxs_pkg::cfg_type                cfg
);
   import nxs_pkg::*;

   logic [PERIOD_MS_W-1:0] period_ms_ff;
   logic [PERIOD_MS_W-1:0] period_ms_in;
   logic [DURATION_W-1:0]  duration_ff;
   logic [DURATION_W-1:0]  duration_in;

   always_comb begin
      period_ms_in = period_ms_ff;
      duration_in  = duration_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PERIOD_SECONDS: begin
               period_ms_in = PERIOD_MS_W'(csr_write_data[PERIOD_W-1:0])
                              * PERIOD_MS_W'(MS_PER_SECOND);
            end
            CSR_DURATION_MILLIS: begin
               duration_in = csr_write_data[DURATION_W-1:0];
            end
            default: begin
               period_ms_in = period_ms_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ms_ff <= PERIOD_MS_W'(RESET_PERIOD_SECONDS) * PERIOD_MS_W'(MS_PER_SECOND);
         duration_ff  <= RESET_DURATION_MS;
      end else begin
         period_ms_ff <= period_ms_in;
         duration_ff  <= duration_in;
      end
   end

   assign cfg.period_ms  = period_ms_ff;
   assign cfg.run_len_ms = duration_ff;

endmodule

// ----- rtl/core/nxs_step.sv -----
// ----------------------------------------------------------------------------
// nxs_step
// Scrub run state and the per-item decision logic; state commits on advance.
// ----------------------------------------------------------------------------
module nxs_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  nxs_pkg::item_type   item,
   input  nxs_pkg::cfg_type    cfg,
   output nxs_pkg::result_type result
);
   import nxs_pkg::*;

   logic                 run_ff, run_in;
   logic                 pend_ff, pend_in;
   time_type             start_ff, start_in;
   time_type             end_ff, end_in;
   time_type             step_time_ff, step_time_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   bright_type           saved_ff, saved_in;

   logic                 is_trig;
   logic                 auto_go;
   logic                 live;
   logic                 done;
   logic                 step_hit;
   time_type             start_eff;
   time_type             step_base_time;
   logic [STEP_W-1:0]    step_base;
   bright_type           saved_eff;
   time_type             el_end;
   time_type             el_run;
   time_type             el_step;

   always_comb begin
      is_trig        = (item.action == ACTION_TRIGGER);
      el_end         = item.now_millis - end_ff;
      auto_go        = !is_trig && !run_ff && (cfg.period_ms != '0)
                       && (el_end >= TIME_W'(cfg.period_ms));
      live           = !is_trig && (run_ff || auto_go);
      start_eff      = (auto_go || pend_ff) ? item.now_millis : start_ff;
      el_run         = item.now_millis - start_eff;
      done           = live && (el_run >= TIME_W'(cfg.run_len_ms));
      step_base_time = auto_go ? '0 : step_time_ff;
      step_base      = auto_go ? '0 : step_ff;
      saved_eff      = auto_go ? item.current_brightness : saved_ff;
      el_step        = item.now_millis - step_base_time;
      step_hit       = live && !done && (el_step >= TIME_W'(STEP_INTERVAL_MS));
   end

   always_comb begin
      result = '0;
      if (is_trig) begin
         result.running          = 1'b1;
         result.brightness_write = 1'b1;
         result.brightness_level = SCRUB_BRIGHTNESS;
         result.colon_off        = 1'b1;
      end else if (live) begin
         result.colon_off = auto_go;
         if (done) begin
            result.brightness_write = 1'b1;
            result.brightness_level = saved_eff;
         end else begin
            result.running          = 1'b1;
            result.brightness_write = auto_go;
            result.brightness_level = auto_go ? SCRUB_BRIGHTNESS : '0;
            result.digits_update    = step_hit;
            for (int i = 0; i < DIGIT_PORTS; i++) begin
               if (step_hit && (i < TUBE_COUNT)) begin
                  result.digit[i] = mod10({1'b0, step_base} + (STEP_W+1)'(i));
               end
            end
         end
      end
   end

   always_comb begin
      run_in       = run_ff;
      pend_in      = pend_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      step_time_in = step_time_ff;
      step_in      = step_ff;
      saved_in     = saved_ff;
      if (advance) begin
         if (is_trig) begin
            run_in       = 1'b1;
            pend_in      = 1'b1;
            start_in     = '0;
            step_time_in = '0;
            step_in      = '0;
            saved_in     = item.current_brightness;
         end else if (live) begin
            run_in       = !done;
            pend_in      = 1'b0;
            start_in     = start_eff;
            saved_in     = saved_eff;
            step_time_in = step_hit ? item.now_millis : step_base_time;
            step_in      = step_hit ? step_base + STEP_W'(1) : step_base;
            if (done) begin
               end_in = item.now_millis;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
         step_time_ff <= '0;
         step_ff      <= '0;
         saved_ff     <= '0;
      end else begin
         run_ff       <= run_in;
         pend_ff      <= pend_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         step_time_ff <= step_time_in;
         step_ff      <= step_in;
         saved_ff     <= saved_in;
      end
   end

endmodule

// ----- sim/tb_nixie_cathode_scrub_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_nixie_cathode_scrub_sequencer
// Feeds ticks and triggers to the scrub sequencer and checks every result item
// against a cycle-free model of the scrub schedule. Covers directed corner
// cases first, then randomized phases over several period/duration settings,
// with random idling on both channels and long result back-pressure.
// ----------------------------------------------------------------------------
module tb_nixie_cathode_scrub_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import nxs_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   nxs_req_if req_ch ();
   nxs_rsp_if rsp_ch ();

   nixie_cathode_scrub_sequencer dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_ch),
      .rsp_chan       (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // schedule model
   logic [PERIOD_W-1:0]   cfg_interval_s;
   logic [DURATION_W-1:0] cfg_run_len_ms;
   logic                  run_on;
   logic                  start_wait;
   time_type              run_begin_ms;
   time_type              last_end_ms;
   time_type              last_step_ms;
   logic [STEP_W-1:0]     step_num;
   bright_type            saved_level;

   item_type    pending_items[$];
   result_type  expected_results[$];
   item_type    item_on_bus;
   result_type  want;

   int unsigned queued_count = 0;
   int unsigned accepted_count = 0;
   int unsigned mismatches = 0;
   int unsigned send_gap;
   int unsigned recv_stall;
   int unsigned hold_left;
   int unsigned long_holds;
   int unsigned idle_cycles;
   int unsigned calm_timer;
   logic        calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (calm) return 0;
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(15, 4);
      return $urandom_range(80, 20);
   endfunction

   function automatic void open_run(input bright_type level, inout result_type r);
      run_on             = 1'b1;
      last_step_ms       = '0;
      step_num           = '0;
      saved_level        = level;
      r.brightness_write = 1'b1;
      r.brightness_level = SCRUB_BRIGHTNESS;
      r.colon_off        = 1'b1;
   endfunction

   function automatic result_type advance_scrub(input item_type it);
      result_type r;
      time_type   since;
      r = '0;
      if (it.action == ACTION_TRIGGER) begin
         open_run(it.current_brightness, r);
         start_wait   = 1'b1;
         run_begin_ms = '0;
         r.running    = 1'b1;
         return r;
      end
      if (!run_on) begin
         if (cfg_interval_s == '0) return r;
         since = it.now_millis - last_end_ms;
         if (since < time_type'(cfg_interval_s) * time_type'(MS_PER_SECOND)) return r;
         open_run(it.current_brightness, r);
         start_wait   = 1'b0;
         run_begin_ms = it.now_millis;
      end else if (start_wait) begin
         start_wait   = 1'b0;
         run_begin_ms = it.now_millis;
      end
      since = it.now_millis - run_begin_ms;
      if (since >= time_type'(cfg_run_len_ms)) begin
         run_on             = 1'b0;
         last_end_ms        = it.now_millis;
         r.brightness_write = 1'b1;
         r.brightness_level = saved_level;
         r.running          = 1'b0;
         return r;
      end
      r.running = 1'b1;
      since = it.now_millis - last_step_ms;
      if (since >= time_type'(STEP_INTERVAL_MS)) begin
         last_step_ms    = it.now_millis;
         r.digits_update = 1'b1;
         for (int i = 0; i < TUBE_COUNT; i++)
            r.digit[i] = digit_type'((int'(step_num) + i) % 10);
         step_num = step_num + 1'b1;
      end
      return r;
   endfunction

   function automatic void queue_item(input logic action, input time_type now_ms,
                                      input bright_type level);
      item_type it;
      it.action             = action;
      it.now_millis         = now_ms;
      it.current_brightness = level;
      pending_items.push_back(it);
      queued_count++;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                         input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%s mismatch at %0t: expected %0d got %0d", name, $realtime,
                     exp_val, act_val);
      end
   endfunction

   task automatic wait_quiet();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_PERIOD_SECONDS) cfg_interval_s = PERIOD_W'(value);
      else cfg_run_len_ms = DURATION_W'(value);
   endtask

   task automatic set_schedule(input int unsigned interval_s, input int unsigned run_len_ms);
      wait_quiet();
      write_reg(CSR_PERIOD_SECONDS, interval_s);
      write_reg(CSR_DURATION_MILLIS, run_len_ms);
   endtask

   task automatic random_phase(input int unsigned interval_s, input int unsigned run_len_ms,
                               input int unsigned count, input bit long_mode,
                               input time_type t0);
      time_type    clock_ms;
      int unsigned roll;
      set_schedule(interval_s, run_len_ms);
      clock_ms = t0;
      repeat (count) begin
         roll = $urandom_range(99);
         if (!long_mode && roll < 5) begin
            queue_item(ACTION_TRIGGER, time_type'({$urandom(), $urandom()}),
                       bright_type'($urandom()));
         end else begin
            // long mode keeps one run going so the step counter wraps
            if (long_mode)
               clock_ms += time_type'($urandom_range(250, 100));
            else if (roll < 65)
               clock_ms += time_type'($urandom_range(250));
            else if (roll < 80)
               clock_ms += time_type'(interval_s * MS_PER_SECOND + $urandom_range(40))
                           - time_type'(20);
            else if (roll < 92)
               clock_ms += time_type'(run_len_ms + $urandom_range(300));
            else if (roll < 96)
               clock_ms = time_type'({$urandom(), $urandom()});
            else
               clock_ms = '1 - time_type'($urandom_range(500));
            queue_item(ACTION_TICK, clock_ms, bright_type'($urandom()));
         end
      end
   endtask

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         cfg_interval_s  = RESET_PERIOD_SECONDS;
         cfg_run_len_ms  = RESET_DURATION_MS;
         run_on          = 1'b0;
         start_wait      = 1'b0;
         run_begin_ms    = '0;
         last_end_ms     = '0;
         last_step_ms    = '0;
         step_num        = '0;
         saved_level     = '0;
         accepted_count  = 0;
         send_gap        = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(advance_scrub(item_on_bus));
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               item_on_bus = pending_items.pop_front();
               req_ch.action             <= item_on_bus.action;
               req_ch.now_millis         <= item_on_bus.now_millis;
               req_ch.current_brightness <= item_on_bus.current_brightness;
               req_ch.valid              <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with two long hold-offs to back up the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = 0;
         hold_left  = 0;
         long_holds = 0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if ((long_holds == 0 && accepted_count >= 500) ||
                   (long_holds == 1 && accepted_count >= 1200)) begin
         long_holds++;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (recv_stall != 0) begin
         recv_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         recv_stall = pick_gap();
         rsp_ch.ready <= (recv_stall == 0);
      end
   end

   // alternate stretches with and without idling
   always @(posedge clock) begin
      if (reset) begin
         calm       <= 1'b0;
         calm_timer <= 200;
      end else if (calm_timer == 0) begin
         calm       <= ~calm;
         calm_timer <= $urandom_range(400, 100);
      end else begin
         calm_timer <= calm_timer - 1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
         end else begin
            want = expected_results.pop_front();
            compare_field("running", 8'(want.running), 8'(rsp_ch.running));
            compare_field("digits_update", 8'(want.digits_update),
                          8'(rsp_ch.digits_update));
            compare_field("digit_zero", 8'(want.digit[0]), 8'(rsp_ch.digit_zero));
            compare_field("digit_one", 8'(want.digit[1]), 8'(rsp_ch.digit_one));
            compare_field("digit_two", 8'(want.digit[2]), 8'(rsp_ch.digit_two));
            compare_field("digit_three", 8'(want.digit[3]), 8'(rsp_ch.digit_three));
            compare_field("digit_four", 8'(want.digit[4]), 8'(rsp_ch.digit_four));
            compare_field("digit_five", 8'(want.digit[5]), 8'(rsp_ch.digit_five));
            compare_field("brightness_write", 8'(want.brightness_write),
                          8'(rsp_ch.brightness_write));
            compare_field("brightness_level", want.brightness_level,
                          rsp_ch.brightness_level);
            compare_field("colon_off", 8'(want.colon_off), 8'(rsp_ch.colon_off));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= QUIET_LIMIT) begin
         $display("tb_nixie_cathode_scrub_sequencer NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                     = 1'b1;
      csr_write_en              = 1'b0;
      csr_index                 = '0;
      csr_write_data            = '0;
      req_ch.valid              = 1'b0;
      req_ch.action             = ACTION_TICK;
      req_ch.now_millis         = '0;
      req_ch.current_brightness = '0;
      rsp_ch.ready              = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset schedule: 600 s period, 12 s runs
      queue_item(ACTION_TICK, 40'd0, 8'h00);
      queue_item(ACTION_TICK, 40'd599999, 8'hFF);
      queue_item(ACTION_TICK, 40'd600000, 8'hA5);
      queue_item(ACTION_TICK, 40'd600119, 8'h01);
      queue_item(ACTION_TICK, 40'd600120, 8'h80);
      queue_item(ACTION_TRIGGER, '1, 8'h5A);
      queue_item(ACTION_TICK, 40'd600200, 8'h7F);
      queue_item(ACTION_TRIGGER, '0, 8'hFF);
      queue_item(ACTION_TICK, 40'hFF_FFFF_FF00, 8'h00);
      queue_item(ACTION_TICK, 40'h00_0000_0010, 8'h11);
      queue_item(ACTION_TICK, 40'd12000, 8'h22);
      queue_item(ACTION_TICK, 40'd612000, 8'hC3);
      queue_item(ACTION_TICK, 40'd624000, 8'h3C);

      // no automatic runs, zero-length runs
      set_schedule(0, 0);
      queue_item(ACTION_TICK, 40'hAA_AAAA_AAAA, 8'h55);
      queue_item(ACTION_TRIGGER, 40'h55_5555_5555, 8'h33);
      queue_item(ACTION_TICK, '1, 8'hEE);

      // start and end in the same tick
      set_schedule(1, 0);
      queue_item(ACTION_TICK, 40'd2000, 8'h9D);
      queue_item(ACTION_TICK, 40'd2500, 8'h62);

      random_phase(1, 500, 280, 1'b0, 40'd0);
      random_phase(0, 300, 220, 1'b0, time_type'({$urandom(), $urandom()}));
      random_phase(2, 0, 220, 1'b0, 40'd5000);
      random_phase(86400, 3600000, 180, 1'b0, 40'hFF_FFF0_0000);
      random_phase(1, 3600000, 320, 1'b1, 40'hFF_FFFF_0000);
      random_phase(600, 12000, 180, 1'b0, 40'd0);
      random_phase(1, 1000, 300, 1'b0, 40'hFF_FFFF_F000);

      wait_quiet();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_nixie_cathode_scrub_sequencer OK");
      else
         $display("tb_nixie_cathode_scrub_sequencer NOT OK");
      $finish;
   end

endmodule
